// File: design/gwpf_pkg.sv
// Shared types and constants for the grid wave path finder.
package gwpf_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ACK     = 3'd0,
        ST_FOUND   = 3'd1,
        ST_UNREACH = 3'd2,
        ST_HDIFF   = 3'd3,
        ST_BAD     = 3'd4
    } t_status;

    localparam logic [1:0] REG_TOL  = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_ROWS = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_HS_RD,
        S_HS_WAIT,
        S_HG_WAIT,
        S_CLR,
        S_POP,
        S_POP_WAIT,
        S_NB_RD,
        S_NB_WAIT,
        S_CA_WAIT,
        S_CB_WAIT,
        S_TB_START,
        S_TB_RD,
        S_TB_WAIT,
        S_OUT
    } t_state;

    // Step tables in order W, N, E, S, NW, NE, SE, SW.
    function automatic logic [1:0] step_dc(input logic [2:0] d);
        case (d)
            3'd0: step_dc = 2'b11;
            3'd1: step_dc = 2'b00;
            3'd2: step_dc = 2'b01;
            3'd3: step_dc = 2'b00;
            3'd4: step_dc = 2'b11;
            3'd5: step_dc = 2'b01;
            3'd6: step_dc = 2'b01;
            default: step_dc = 2'b11;
        endcase
    endfunction

    function automatic logic [1:0] step_dr(input logic [2:0] d);
        case (d)
            3'd0: step_dr = 2'b00;
            3'd1: step_dr = 2'b11;
            3'd2: step_dr = 2'b00;
            3'd3: step_dr = 2'b01;
            3'd4: step_dr = 2'b11;
            3'd5: step_dr = 2'b11;
            3'd6: step_dr = 2'b01;
            default: step_dr = 2'b01;
        endcase
    endfunction

endpackage

// File: design/gwpf_if.sv
// Valid/ready channel interfaces for commands and results.
interface gwpf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic [15:0] height;
    logic [5:0]  goal_col;
    logic [5:0]  goal_row;
    logic [11:0] path_index;
    modport source (output valid, cmd, cell_col, cell_row, height, goal_col, goal_row,
                    path_index, input ready);
    modport sink (input valid, cmd, cell_col, cell_row, height, goal_col, goal_row,
                  path_index, output ready);
endinterface

interface gwpf_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [12:0] path_length;
    logic [5:0]  point_col;
    logic [5:0]  point_row;
    modport source (output valid, status, path_length, point_col, point_row, input ready);
    modport sink (input valid, status, path_length, point_col, point_row, output ready);
endinterface

// File: design/gwpf_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module gwpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/grid_wave_path_finder_top.sv
// Top level of the grid wave path finder: command decode, wave search and path trace.
//  channel   dir  payload                                              transfer
//  s_cmd     in   cmd cell_col cell_row height goal_col goal_row idx  valid & ready
//  m_res     out  status path_length point_col point_row               valid & ready
//  cfg       in   i_cfg_we i_cfg_idx i_cfg_data                        i_cfg_we high
// A write answers in the cycle after its transfer; a read first passes through S_OUT. A search
// reads the end-point heights, clears the whole wave map, then checks the eight neighbours
// of each dequeued cell and traces the path back step by step, paced by the single read
// port of the height and wave memories.
// Reset is synchronous; it clears control state and the stored path length and sets the configuration to its defaults.
// One command is in flight at a time; a result waits in the output register.
module grid_wave_path_finder_top #(
    parameter int MAX_COLS    = 64,
    parameter int MAX_ROWS    = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    gwpf_cmd_if.sink    s_cmd,
    gwpf_res_if.source  m_res
);
    import gwpf_pkg::*;

    localparam int CB    = $clog2(MAX_COLS);
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int AB    = CB + RB;
    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int QB    = AB + 1;
    localparam int WB    = 13;
    localparam logic [WB-1:0] NO_WAVE = '1;

    logic [15:0] r_tol;
    logic [6:0]  r_cols, r_rows;
    logic [8:0]  w_gc, w_gr;

    t_state r_state, n_state;
    logic [8:0]  r_sc, r_sr, r_gc, r_gr;
    logic [HEIGHT_BITS-1:0] r_h0;
    logic [11:0] r_idx;
    logic [12:0] r_plen;
    logic [QB-1:0] r_head, r_tail;
    logic [AB:0]   r_clr;
    logic [8:0]  r_c, r_r;
    logic [WB-1:0] r_w;
    logic [2:0]  r_d;
    logic        r_reached;
    logic [12:0] r_k;
    logic        r_vld;
    logic [2:0]  r_st;
    logic [5:0]  r_pc, r_pr;

    // memories
    logic                   h_we, wv_we, q_we, p_we;
    logic [AB-1:0]          h_wa, h_ra, wv_wa, wv_ra, q_ra, p_wa, p_ra;
    logic [QB-2:0]          q_wa;
    logic [HEIGHT_BITS-1:0] h_wd, h_rd;
    logic [WB-1:0]          wv_wd, wv_rd;
    logic [AB-1:0]          q_wd, q_rd, p_wd, p_rd;

    gwpf_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(CELLS)) u_hmap (
        .i_clk, .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd), .i_raddr(h_ra), .o_rdata(h_rd));
    gwpf_ram #(.WIDTH(WB), .DEPTH(CELLS)) u_wmap (
        .i_clk, .i_we(wv_we), .i_waddr(wv_wa), .i_wdata(wv_wd), .i_raddr(wv_ra),
        .o_rdata(wv_rd));
    gwpf_ram #(.WIDTH(AB), .DEPTH(CELLS)) u_queue (
        .i_clk, .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd), .i_raddr(q_ra), .o_rdata(q_rd));
    gwpf_ram #(.WIDTH(AB), .DEPTH(CELLS)) u_path (
        .i_clk, .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd), .i_raddr(p_ra), .o_rdata(p_rd));

    function automatic logic [AB-1:0] addr_of(input logic [8:0] c, input logic [8:0] r);
        addr_of = {r[RB-1:0], c[CB-1:0]};
    endfunction

    assign w_gc = ({2'b00, r_cols} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {2'b00, r_cols};
    assign w_gr = ({2'b00, r_rows} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b00, r_rows};

    // neighbor of current cell
    logic [8:0] nb_c, nb_r;
    logic [1:0] nb_dc, nb_dr;
    logic       nb_in;
    always_comb begin
        nb_dc = step_dc(r_d);
        nb_dr = step_dr(r_d);
        nb_c  = r_c + {{7{nb_dc[1]}}, nb_dc};
        nb_r  = r_r + {{7{nb_dr[1]}}, nb_dr};
        nb_in = (nb_c < w_gc) && (nb_r < w_gr);
    end

    logic [HEIGHT_BITS-1:0] h_gap;
    logic                   h_near;
    assign h_gap  = (h_rd > r_h0) ? h_rd - r_h0 : r_h0 - h_rd;
    assign h_near = 32'(h_gap) < 32'(r_tol);

    logic in_cell_ok, in_goal_ok;
    assign in_cell_ok = ({3'd0, s_cmd.cell_col} < w_gc) && ({3'd0, s_cmd.cell_row} < w_gr);
    assign in_goal_ok = ({3'd0, s_cmd.goal_col} < w_gc) && ({3'd0, s_cmd.goal_row} < w_gr);

    assign s_cmd.ready = (r_state == S_IDLE) && !r_vld;
    assign m_res.valid = r_vld;
    assign m_res.status = r_st;
    assign m_res.path_length = r_plen;
    assign m_res.point_col = r_pc;
    assign m_res.point_row = r_pr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= 16'd1;
            r_cols <= 7'd64;
            r_rows <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TOL:  r_tol  <= i_cfg_data;
                REG_COLS: r_cols <= i_cfg_data[6:0];
                REG_ROWS: r_rows <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic            fin;
    logic [2:0]      fin_st;
    logic [12:0]     n_plen;
    logic            ld_rd;

    always_comb begin
        n_state = r_state;
        h_we = 1'b0; h_wa = addr_of(r_sc, r_sr); h_wd = '0; h_ra = addr_of(r_sc, r_sr);
        wv_we = 1'b0; wv_wa = '0; wv_wd = NO_WAVE; wv_ra = addr_of(nb_c, nb_r);
        q_we = 1'b0; q_wa = r_tail[QB-2:0]; q_wd = addr_of(nb_c, nb_r);
        q_ra = r_head[QB-2:0];
        p_we = 1'b0; p_wa = r_k[AB-1:0]; p_wd = addr_of(r_c, r_r);
        p_ra = r_idx[AB-1:0];
        fin = 1'b0; fin_st = ST_ACK; n_plen = r_plen; ld_rd = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_cmd.valid && s_cmd.ready) begin
                    case (t_cmd'(s_cmd.cmd))
                        CMD_WRITE: begin
                            h_we = in_cell_ok;
                            h_wa = addr_of({3'd0, s_cmd.cell_col}, {3'd0, s_cmd.cell_row});
                            h_wd = HEIGHT_BITS'(s_cmd.height);
                            fin = 1'b1; fin_st = in_cell_ok ? ST_ACK : ST_BAD;
                        end
                        CMD_SEARCH: begin
                            if (in_cell_ok && in_goal_ok) n_state = S_HS_RD;
                            else begin fin = 1'b1; fin_st = ST_BAD; end
                        end
                        CMD_READ: begin
                            p_ra = s_cmd.path_index[AB-1:0];
                            n_state = S_OUT;
                        end
                        default: begin fin = 1'b1; fin_st = ST_BAD; end
                    endcase
                end
            end
            S_HS_RD: begin
                h_ra = addr_of(r_sc, r_sr);
                n_state = S_HS_WAIT;
            end
            S_HS_WAIT: begin
                h_ra = addr_of(r_gc, r_gr);
                n_state = S_HG_WAIT;
            end
            S_HG_WAIT: begin
                if (32'(h_gap) > 32'(r_tol)) begin
                    fin = 1'b1; fin_st = ST_HDIFF; n_plen = '0;
                end else if (r_sc == r_gc && r_sr == r_gr) begin
                    p_we = 1'b1; p_wa = '0; p_wd = addr_of(r_sc, r_sr);
                    fin = 1'b1; fin_st = ST_FOUND; n_plen = 13'd1;
                end else n_state = S_CLR;
            end
            S_CLR: begin
                wv_we = 1'b1; wv_wa = r_clr[AB-1:0]; wv_wd = NO_WAVE;
                if (r_clr == (AB+1)'(CELLS - 1)) begin
                    n_state = S_POP;
                end
                if (r_clr[AB-1:0] == addr_of(r_sc, r_sr)) wv_wd = '0;
                if (r_clr == (AB+1)'(CELLS - 1)) begin
                    q_we = 1'b1; q_wa = '0; q_wd = addr_of(r_sc, r_sr);
                end
            end
            S_POP: begin
                if (r_head == r_tail || r_reached) begin
                    if (r_reached) begin
                        wv_ra = addr_of(r_gc, r_gr);
                        n_state = S_TB_START;
                    end else begin
                        p_we = 1'b1; p_wa = '0; p_wd = addr_of(r_sc, r_sr);
                        fin = 1'b1; fin_st = ST_UNREACH; n_plen = 13'd1;
                    end
                end else n_state = S_POP_WAIT;
            end
            S_POP_WAIT: begin
                wv_ra = q_rd;
                n_state = S_NB_RD;
            end
            S_NB_RD: begin
                if (!nb_in) begin
                    n_state = (r_d == 3'd7) ? S_POP : S_NB_RD;
                end else begin
                    wv_ra = addr_of(nb_c, nb_r);
                    h_ra = addr_of(nb_c, nb_r);
                    n_state = S_NB_WAIT;
                end
            end
            S_NB_WAIT: begin
                h_ra = addr_of(r_c, nb_r);
                if (wv_rd != NO_WAVE || !h_near) begin
                    n_state = (r_d == 3'd7) ? S_POP : S_NB_RD;
                end else if (r_d[2]) begin
                    n_state = S_CA_WAIT;
                end else n_state = S_CB_WAIT;
            end
            S_CA_WAIT: begin
                h_ra = addr_of(nb_c, r_r);
                if (!h_near) n_state = (r_d == 3'd7) ? S_POP : S_NB_RD;
                else n_state = S_CB_WAIT;
            end
            S_CB_WAIT: begin
                if (!r_d[2] || h_near) begin
                    wv_we = 1'b1; wv_wa = addr_of(nb_c, nb_r); wv_wd = r_w + 1'b1;
                    q_we = (r_tail != QB'(CELLS));
                end
                n_state = (r_d == 3'd7) ? S_POP : S_NB_RD;
            end
            S_TB_START: begin
                wv_ra = addr_of(r_gc, r_gr);
                n_state = S_TB_RD;
            end
            S_TB_RD: begin
                p_we = 1'b1;
                if (r_k == '0) begin
                    fin = 1'b1; fin_st = ST_FOUND; n_plen = r_plen;
                end else if (!nb_in) begin
                    n_state = S_TB_RD;
                end else begin
                    wv_ra = addr_of(nb_c, nb_r);
                    n_state = S_TB_WAIT;
                end
            end
            S_TB_WAIT: begin
                n_state = S_TB_RD;
            end
            S_OUT: begin
                ld_rd = 1'b1;
                fin = 1'b1;
                fin_st = ({1'b0, r_idx} < r_plen) ? ST_ACK : ST_BAD;
            end
            default: n_state = S_IDLE;
        endcase
        if (fin) n_state = S_IDLE;
    end

    // S_OUT is entered in the cycle after the read address is presented in S_IDLE
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
            r_plen  <= '0;
        end else begin
            r_state <= n_state;
            if (m_res.valid && m_res.ready) r_vld <= 1'b0;
            if (fin) begin
                r_vld  <= 1'b1;
                r_plen <= n_plen;
            end
            if (r_state == S_TB_START) r_plen <= 13'(wv_rd) + 13'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_st <= fin_st;
            r_pc <= (ld_rd && fin_st == ST_ACK) ? 6'(p_rd[CB-1:0]) : 6'd0;
            r_pr <= (ld_rd && fin_st == ST_ACK) ? 6'(p_rd[AB-1:CB]) : 6'd0;
        end
        case (r_state)
            S_IDLE: begin
                r_sc  <= {3'd0, s_cmd.cell_col};
                r_sr  <= {3'd0, s_cmd.cell_row};
                r_gc  <= {3'd0, s_cmd.goal_col};
                r_gr  <= {3'd0, s_cmd.goal_row};
                r_idx <= s_cmd.path_index;
                r_clr <= '0;
                r_head <= '0;
                r_tail <= QB'(1);
                r_reached <= 1'b0;
            end
            S_HS_WAIT: r_h0 <= h_rd;
            S_CLR: r_clr <= r_clr + 1'b1;
            S_POP: begin
                if (r_head != r_tail && !r_reached) r_head <= r_head + 1'b1;
            end
            S_POP_WAIT: begin
                r_c <= {{(9-CB){1'b0}}, q_rd[CB-1:0]};
                r_r <= {{(9-RB){1'b0}}, q_rd[AB-1:CB]};
                r_d <= '0;
            end
            S_NB_RD: begin
                if (r_d == 3'd0) r_w <= wv_rd;
                if (!nb_in) r_d <= r_d + 1'b1;
            end
            S_NB_WAIT: begin
                if (wv_rd != NO_WAVE || !h_near) r_d <= r_d + 1'b1;
            end
            S_CA_WAIT: if (!h_near) r_d <= r_d + 1'b1;
            S_CB_WAIT: begin
                if (!r_d[2] || h_near) begin
                    if (r_tail != QB'(CELLS)) r_tail <= r_tail + 1'b1;
                    if (nb_c == r_gc && nb_r == r_gr) r_reached <= 1'b1;
                end
                r_d <= r_d + 1'b1;
            end
            S_TB_START: begin
                r_c <= r_gc;
                r_r <= r_gr;
                r_d <= '0;
                r_w <= wv_rd;
                r_k <= (wv_rd >= WB'(CELLS)) ? 13'(CELLS - 1) : wv_rd;
            end
            S_TB_RD: if (r_k != '0 && !nb_in) r_d <= r_d + 1'b1;
            S_TB_WAIT: begin
                if (wv_rd == r_w - 1'b1) begin
                    r_c <= nb_c; r_r <= nb_r; r_w <= wv_rd; r_d <= '0;
                    r_k <= r_k - 1'b1;
                end else r_d <= r_d + 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.ready |-> (r_state == S_IDLE && !r_vld)) else $error("ready outside idle");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !m_res.ready) |=> (r_vld && $stable(r_st))) else $error("result lost");
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= 13'(CELLS)) else $error("path length overflow");
    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail) else $error("queue underflow");
`endif
endmodule
